### rtl/core/tgad_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// Used by tgad_front, tgad_queue, tgad_back and tga_rle_pixel_decoder_unit.
package tgad_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_COMPRESSED_MODE = 2'd1;
   localparam logic [1:0] CSR_IMAGE_PIXELS    = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int BPP_W       = 3;
   localparam int PIXELS_W    = 15;

   // Normalised pixel sizes in bytes
   localparam logic [2:0] PIX_2BYTE = 3'd2;
   localparam logic [2:0] PIX_3BYTE = 3'd3;
   localparam logic [2:0] PIX_4BYTE = 3'd4;

   localparam logic [2:0]  BPP_RESET    = 3'd4;
   localparam logic        MODE_RESET   = 1'b0;
   localparam logic [14:0] PIXELS_RESET = 15'd16384;

   // Packet header fields
   localparam int HDR_RUN_BIT = 7;

   // One finished pixel on its way from the front to the back
   typedef struct packed {
      logic [23:0] held_bytes;
      logic [7:0]  last_byte;
      logic [2:0]  pixel_size;
      logic [7:0]  run_length;
      logic        image_done;
   } pixel_item_type;

endpackage

### rtl/core/tga_rle_pixel_decoder_unit.sv
// True-colour TGA pixel-data decoder (image types 2 and 10, 2/3/4 bytes per
// pixel). Feed the pixel-data bytes after the header; one byte is taken every
// cycle while req_ready is high, and req_ready drops only when the two-entry
// pixel queue is full because rsp_ready is held low. A pixel result passes
// through the queue and the back stage's output register before it appears on
// the rsp channel. The packet state and pixel counter are updated for each
// accepted byte in the front stage, which sets the one-byte-per-cycle rate.
// Bytes after the last image pixel are dropped; only reset clears the pixel
// count. Write the csr registers only while the decoder is idle.
module tga_rle_pixel_decoder_unit #(
   parameter int MAX_PIXELS = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_run_length,
   output logic        rsp_image_done,
   input  logic        csr_write_en,
   input  logic [tgad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgad_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FULL_W = $clog2(MAX_PIXELS + 1);
   localparam int CNT_W  = (FULL_W < tgad_pkg::PIXELS_W) ? FULL_W : tgad_pkg::PIXELS_W;

   logic [tgad_pkg::BPP_W-1:0]    bpp_ff;
   logic                          mode_ff;
   logic [tgad_pkg::PIXELS_W-1:0] pixels_ff;
   logic [CNT_W-1:0]              total_pixels;

   logic                     byte_accept;
   logic                     push, full, pop, not_empty;
   tgad_pkg::pixel_item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= tgad_pkg::BPP_RESET;
         mode_ff   <= tgad_pkg::MODE_RESET;
         pixels_ff <= tgad_pkg::PIXELS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            tgad_pkg::CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_wdata[tgad_pkg::BPP_W-1:0];
            tgad_pkg::CSR_COMPRESSED_MODE: mode_ff   <= csr_wdata[0];
            tgad_pkg::CSR_IMAGE_PIXELS:    pixels_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cap the image size at MAX_PIXELS
   always_comb begin
      if (32'(pixels_ff) > 32'(MAX_PIXELS)) begin
         total_pixels = CNT_W'(MAX_PIXELS);
      end else begin
         total_pixels = pixels_ff[CNT_W-1:0];
      end
   end

   assign req_ready   = !full;
   assign byte_accept = req_valid && req_ready;

   tgad_front #(
      .CNT_W (CNT_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .byte_accept     (byte_accept),
      .data_byte       (req_data_byte),
      .bytes_per_pixel (bpp_ff),
      .compressed_mode (mode_ff),
      .total_pixels    (total_pixels),
      .push            (push),
      .push_item       (push_item)
   );

   tgad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_item  (pop_item)
   );

   tgad_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (not_empty),
      .item           (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_run_length (rsp_run_length),
      .rsp_image_done (rsp_image_done)
   );

endmodule

### rtl/core/tgad_front.sv
// Front of the decoder: takes stream bytes, tracks packets, gathers pixel bytes,
// clamps runs and counts pixels. Depends on tgad_pkg.
module tgad_front #(
   parameter int CNT_W = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              data_byte,
   input  logic [2:0]              bytes_per_pixel,
   input  logic                    compressed_mode,
   input  logic [CNT_W-1:0]        total_pixels,
   output logic                    push,
   output tgad_pkg::pixel_item_type push_item
);

   localparam int SUM_W = (CNT_W > 8) ? CNT_W : 8;

   logic             expect_header_ff, expect_header_in;
   logic [1:0]       byte_index_ff, byte_index_in;
   logic [23:0]      held_bytes_ff, held_bytes_in;
   logic [6:0]       raw_left_ff, raw_left_in;
   logic             packet_is_run_ff, packet_is_run_in;
   logic [7:0]       run_count_ff, run_count_in;
   logic [CNT_W-1:0] pixels_done_ff, pixels_done_in;

   logic [2:0]       size;
   logic             image_over;
   logic             pixel_ends;
   logic [7:0]       len_raw;
   logic [SUM_W-1:0] left_ext, len_ext, len_clamped;

   always_comb begin
      if (bytes_per_pixel < tgad_pkg::PIX_2BYTE) begin
         size = tgad_pkg::PIX_2BYTE;
      end else if (bytes_per_pixel > tgad_pkg::PIX_4BYTE) begin
         size = tgad_pkg::PIX_4BYTE;
      end else begin
         size = bytes_per_pixel;
      end
   end

   assign image_over = (pixels_done_ff >= total_pixels);
   assign pixel_ends = ({1'b0, byte_index_ff} + 3'd1) >= size;

   always_comb begin
      if (compressed_mode && packet_is_run_ff) begin
         len_raw = (run_count_ff == 8'd0) ? 8'd1 : run_count_ff;
      end else begin
         len_raw = 8'd1;
      end
      left_ext = SUM_W'(total_pixels - pixels_done_ff);
      len_ext  = SUM_W'(len_raw);
      len_clamped = (len_ext > left_ext) ? left_ext : len_ext;
   end

   always_comb begin
      expect_header_in = expect_header_ff;
      byte_index_in    = byte_index_ff;
      held_bytes_in    = held_bytes_ff;
      raw_left_in      = raw_left_ff;
      packet_is_run_in = packet_is_run_ff;
      run_count_in     = run_count_ff;
      pixels_done_in   = pixels_done_ff;
      push             = 1'b0;
      if (byte_accept && !image_over) begin
         if (compressed_mode && expect_header_ff) begin
            packet_is_run_in = data_byte[tgad_pkg::HDR_RUN_BIT];
            run_count_in     = {1'b0, data_byte[6:0]} + 8'd1;
            raw_left_in      = data_byte[6:0];
            expect_header_in = 1'b0;
            byte_index_in    = 2'd0;
         end else if (!pixel_ends) begin
            case (byte_index_ff)
               2'd0:    held_bytes_in[7:0]   = data_byte;
               2'd1:    held_bytes_in[15:8]  = data_byte;
               2'd2:    held_bytes_in[23:16] = data_byte;
               default: held_bytes_in = held_bytes_ff;
            endcase
            byte_index_in = byte_index_ff + 2'd1;
         end else begin
            push          = 1'b1;
            byte_index_in = 2'd0;
            if (compressed_mode) begin
               if (packet_is_run_ff || raw_left_ff == 7'd0) begin
                  expect_header_in = 1'b1;
               end else begin
                  raw_left_in = raw_left_ff - 7'd1;
               end
            end
            pixels_done_in = pixels_done_ff + len_clamped[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      push_item.held_bytes = held_bytes_ff;
      push_item.last_byte  = data_byte;
      push_item.pixel_size = size;
      push_item.run_length = len_clamped[7:0];
      push_item.image_done = (pixels_done_in >= total_pixels);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         byte_index_ff    <= 2'd0;
         held_bytes_ff    <= 24'd0;
         raw_left_ff      <= 7'd0;
         packet_is_run_ff <= 1'b0;
         run_count_ff     <= 8'd0;
         pixels_done_ff   <= '0;
      end else begin
         expect_header_ff <= expect_header_in;
         byte_index_ff    <= byte_index_in;
         held_bytes_ff    <= held_bytes_in;
         raw_left_ff      <= raw_left_in;
         packet_is_run_ff <= packet_is_run_in;
         run_count_ff     <= run_count_in;
         pixels_done_ff   <= pixels_done_in;
      end
   end

endmodule

### rtl/core/tgad_queue.sv
// Two-entry queue of finished pixel items between front and back.
// Depends on tgad_pkg for the item type.
module tgad_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tgad_pkg::pixel_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output tgad_pkg::pixel_item_type pop_item
);

   tgad_pkg::pixel_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/tgad_back.sv
// Back of the decoder: unpacks a pixel item into RGBA and holds the result
// in the output register. Depends on tgad_pkg.
module tgad_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  tgad_pkg::pixel_item_type item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue,
   output logic [7:0]               rsp_alpha,
   output logic [7:0]               rsp_run_length,
   output logic                     rsp_image_done
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff, len_ff;
   logic       done_ff;
   logic [7:0] red_in, green_in, blue_in, alpha_in;
   logic [7:0] b0, b1, b2, bl;

   assign b0 = item.held_bytes[7:0];
   assign b1 = item.held_bytes[15:8];
   assign b2 = item.held_bytes[23:16];
   assign bl = item.last_byte;

   // take a new item when the output register is empty or being drained
   assign pop = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (item.pixel_size)
         tgad_pkg::PIX_4BYTE: begin
            red_in   = b2;
            green_in = b1;
            blue_in  = b0;
            alpha_in = bl;
         end
         tgad_pkg::PIX_3BYTE: begin
            red_in   = bl;
            green_in = b1;
            blue_in  = b0;
            alpha_in = 8'hff;
         end
         default: begin
            // 5-5-5 plus alpha bit, little-endian word
            red_in   = {bl[6:2], 3'b000};
            green_in = {bl[1:0], b0[7:5], 3'b000};
            blue_in  = {b0[4:0], 3'b000};
            alpha_in = {bl[7], 7'b0000000};
         end
      endcase
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         len_ff   <= item.run_length;
         done_ff  <= item.image_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_alpha      = alpha_ff;
   assign rsp_run_length = len_ff;
   assign rsp_image_done = done_ff;

endmodule

### tb/tb_tga_rle_pixel_decoder_unit.sv
// Self-checking testbench for tga_rle_pixel_decoder_unit: byte streams in, RGBA pixels out.
// A scoreboard class predicts every pixel from the accepted bytes and the csr settings.
// Depends on tgad_pkg and the decoder RTL only.
module tb_tga_rle_pixel_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PIXELS    = 16384;
   localparam int RANDOM_BYTES  = 1950;
   localparam int PHASE_BYTES   = 110;
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] run_length;
      logic       image_done;
   } pixel_result_type;

   class pixel_checker;
      logic [2:0]       bpp_reg;
      logic             rle_reg;
      logic [14:0]      image_reg;
      logic             want_header;
      int               gather_idx;
      logic [23:0]      gathered;
      logic [6:0]       raw_remaining;
      logic             in_run;
      logic [7:0]       run_total;
      int               pixels_done;
      pixel_result_type pending_pixels[$];
      int               errors;
      int               bytes_used;
      int               bytes_dropped;
      int               pixels_checked;
      int               run_results;
      int               clamped_runs;

      function new();
         bpp_reg        = tgad_pkg::BPP_RESET;
         rle_reg        = tgad_pkg::MODE_RESET;
         image_reg      = tgad_pkg::PIXELS_RESET;
         want_header    = 1'b1;
         gather_idx     = 0;
         gathered       = '0;
         raw_remaining  = '0;
         in_run         = 1'b0;
         run_total      = '0;
         pixels_done    = 0;
         errors         = 0;
         bytes_used     = 0;
         bytes_dropped  = 0;
         pixels_checked = 0;
         run_results    = 0;
         clamped_runs   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [14:0] value);
         case (idx)
            tgad_pkg::CSR_BYTES_PER_PIXEL: bpp_reg = value[2:0];
            tgad_pkg::CSR_COMPRESSED_MODE: rle_reg = value[0];
            tgad_pkg::CSR_IMAGE_PIXELS:    image_reg = value;
            default: ;
         endcase
      endfunction

      function int pixel_bytes();
         if (bpp_reg < tgad_pkg::PIX_2BYTE) return tgad_pkg::PIX_2BYTE;
         if (bpp_reg > tgad_pkg::PIX_4BYTE) return tgad_pkg::PIX_4BYTE;
         return bpp_reg;
      endfunction

      function int image_total();
         return (image_reg > MAX_PIXELS) ? MAX_PIXELS : image_reg;
      endfunction

      function bit finished();
         return pixels_done >= image_total();
      endfunction

      // true when the next byte starts a fresh pixel, or a fresh packet in run-length mode, or the image is finished
      function bit aligned();
         return finished() || (gather_idx == 0 && (!rle_reg || want_header));
      endfunction

      function void take_byte(logic [7:0] b);
         int               size;
         int               len;
         int               left;
         pixel_result_type px;
         size = pixel_bytes();
         if (finished()) begin
            bytes_dropped++;
            return;
         end
         bytes_used++;
         if (rle_reg && want_header) begin
            in_run        = b[tgad_pkg::HDR_RUN_BIT];
            run_total     = {1'b0, b[6:0]} + 8'd1;
            raw_remaining = b[6:0];
            want_header   = 1'b0;
            gather_idx    = 0;
            return;
         end
         if (gather_idx + 1 < size) begin
            gathered[8*gather_idx +: 8] = b;
            gather_idx++;
            return;
         end
         case (size)
            tgad_pkg::PIX_4BYTE: begin
               px.red   = gathered[23:16];
               px.green = gathered[15:8];
               px.blue  = gathered[7:0];
               px.alpha = b;
            end
            tgad_pkg::PIX_3BYTE: begin
               px.red   = b;
               px.green = gathered[15:8];
               px.blue  = gathered[7:0];
               px.alpha = 8'hff;
            end
            default: begin
               // 5-5-5 plus alpha bit, low byte first
               px.red   = {b[6:2], 3'b000};
               px.green = {b[1:0], gathered[7:5], 3'b000};
               px.blue  = {gathered[4:0], 3'b000};
               px.alpha = {b[7], 7'b0};
            end
         endcase
         gather_idx = 0;
         len = 1;
         if (rle_reg) begin
            if (in_run) begin
               len = (run_total == 0) ? 1 : run_total;
               want_header = 1'b1;
            end else if (raw_remaining == 0) begin
               want_header = 1'b1;
            end else begin
               raw_remaining = raw_remaining - 7'd1;
            end
         end
         left = image_total() - pixels_done;
         if (len > left) begin
            len = left;
            clamped_runs++;
         end
         pixels_done += len;
         if (len > 1) run_results++;
         px.run_length = len[7:0];
         px.image_done = finished();
         pending_pixels.push_back(px);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            errors++;
            $display({"%0t: unexpected pixel, expected none, ",
                      "actual r=%0d g=%0d b=%0d a=%0d len=%0d done=%0d"},
                     $time, got.red, got.green, got.blue, got.alpha, got.run_length,
                     got.image_done);
            return;
         end
         want = pending_pixels.pop_front();
         pixels_checked++;
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("alpha", want.alpha, got.alpha);
         compare_field("run_length", want.run_length, got.run_length);
         compare_field("image_done", want.image_done, got.image_done);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_run_length;
   logic        rsp_image_done;
   logic        csr_write_en;
   logic [tgad_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tgad_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pixel_checker chk;
   bit           req_take;
   bit           rsp_take;
   bit           hold_off;
   int           sender_pct;
   int           stall_pct;
   int           stall_cycles;

   tga_rle_pixel_decoder_unit #(
      .MAX_PIXELS(MAX_PIXELS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_alpha     (rsp_alpha),
      .rsp_run_length(rsp_run_length),
      .rsp_image_done(rsp_image_done),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Inputs only move at rising edges, so the handshakes seen here are the ones taken
   // at the next edge.
   always @(negedge clock) begin
      req_take = !reset && req_valid && req_ready;
      rsp_take = !reset && rsp_valid && rsp_ready;
      if (!reset && req_valid && !req_ready) stall_cycles++;
      if (req_take) chk.take_byte(req_data_byte);
      if (rsp_take) begin
         chk.check_pixel(pixel_result_type'({rsp_red, rsp_green, rsp_blue, rsp_alpha,
                                             rsp_run_length, rsp_image_done}));
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(negedge clock);
         if (reset || csr_write_en || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      if (sender_pct > 0 && $urandom_range(0, 99) < sender_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (!req_take);
   endtask

   // Drop valid, wait for every pixel owed, then let the front stage settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (chk.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value[tgad_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      chk.write_reg(idx, value[tgad_pkg::CSR_DATA_W-1:0]);
   endtask

   task automatic apply_setting(input int bpp, input int rle, input int pixels);
      csr_write(tgad_pkg::CSR_BYTES_PER_PIXEL, bpp);
      csr_write(tgad_pkg::CSR_COMPRESSED_MODE, rle);
      csr_write(tgad_pkg::CSR_IMAGE_PIXELS, pixels);
      csr_write_en <= 1'b0;
   endtask

   // One packet (or a burst of pixels when uncompressed), now and then plain noise.
   task automatic send_packet(inout int sent);
      int   size;
      int   count;
      int   n;
      logic run;
      if ($urandom_range(0, 99) < 8) begin
         n = $urandom_range(1, 5);
      end else begin
         while (!chk.aligned()) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
         end
         size = chk.pixel_bytes();
         if (chk.rle_reg) begin
            count = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(0, 127);
            // keep the pixel budget for the rest of the run
            if (chk.pixels_done > 12000) count = count % 4;
            run = $urandom_range(0, 1);
            send_byte({run, 7'(count)});
            sent++;
            n = run ? size : (count + 1) * size;
         end else begin
            n = $urandom_range(1, 8) * size;
         end
      end
      repeat (n) begin
         send_byte(8'($urandom_range(0, 255)));
         sent++;
      end
   endtask

   initial begin
      int phase;
      int pixels;
      int used_goal;
      int sent;
      int bpp_cycle[8] = '{4, 2, 3, 0, 5, 1, 7, 6};
      chk           = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      hold_off      = 1'b0;
      sender_pct    = 0;
      stall_pct     = 0;
      stall_cycles  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each pixel size, uncompressed; 4-byte pixels at their byte extremes
      apply_setting(tgad_pkg::PIX_4BYTE, 0, MAX_PIXELS);
      repeat (4) send_byte(8'h00);
      repeat (4) send_byte(8'hff);
      drain();
      apply_setting(tgad_pkg::PIX_3BYTE, 0, MAX_PIXELS);
      send_byte(8'ha5);
      send_byte(8'h5a);
      send_byte(8'hc3);
      drain();
      apply_setting(tgad_pkg::PIX_2BYTE, 0, MAX_PIXELS);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'he0);
      send_byte(8'h03);
      drain();

      // Directed run-length: shortest run, two raw pixels, longest run
      apply_setting(tgad_pkg::PIX_2BYTE, 1, MAX_PIXELS);
      send_byte(8'h80);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h01);
      send_byte(8'h1f);
      send_byte(8'h7c);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hff);
      send_byte(8'h55);
      send_byte(8'haa);
      drain();

      // Run that overshoots the image end, then bytes past the end
      apply_setting(tgad_pkg::PIX_2BYTE, 1, chk.pixels_done + 3);
      send_byte(8'h89);
      send_byte(8'h0f);
      send_byte(8'hf0);
      send_byte(8'h77);
      send_byte(8'h88);
      drain();

      // Zero-sized image: everything is dropped
      apply_setting(tgad_pkg::PIX_2BYTE, 1, 0);
      send_byte(8'h81);
      send_byte(8'h42);
      drain();

      // count every accepted byte, dropped ones too, towards the random budget
      used_goal = chk.bytes_used + chk.bytes_dropped + RANDOM_BYTES;
      phase = 0;
      while (chk.bytes_used + chk.bytes_dropped < used_goal && phase < 60) begin
         if (phase == 3) pixels = 32767;
         else if (phase == 9) pixels = chk.pixels_done + 1;
         else if (phase % 5 == 4) pixels = chk.pixels_done + $urandom_range(2, 40);
         else pixels = MAX_PIXELS;
         apply_setting(bpp_cycle[phase % 8], (phase % 3 != 2), pixels);
         case (phase % 4)
            0: begin sender_pct = 0;  stall_pct <= 0;  end
            1: begin sender_pct = 84; stall_pct <= 0;  end
            2: begin sender_pct = 0;  stall_pct <= 84; end
            default: begin sender_pct = 29; stall_pct <= 29; end
         endcase
         if (phase == 8) begin
            // long receiver hold-off while bytes keep coming: fill the queue, stall the input
            fork
               begin
                  @(negedge clock);
                  hold_off = 1'b1;
                  repeat (HOLD_CYCLES) @(negedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         sent = 0;
         while (sent < PHASE_BYTES) send_packet(sent);
         drain();
         phase++;
      end

      if (chk.pending_pixels.size() != 0) begin
         chk.errors++;
         $display("%0t: %0d expected pixels never arrived", $time, chk.pending_pixels.size());
      end
      $display("Covered %0d decoded bytes and %0d dropped past the image end over %0d phases;",
               chk.bytes_used, chk.bytes_dropped, phase);
      $display("%0d pixels checked, %0d runs, %0d clamped, %0d input stall cycles.",
               chk.pixels_checked, chk.run_results, chk.clamped_runs, stall_cycles);
      if (chk.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/core/tgad_pkg.sv
rtl/core/tgad_front.sv
rtl/core/tgad_queue.sv
rtl/core/tgad_back.sv
rtl/core/tga_rle_pixel_decoder_unit.sv
tb/tb_tga_rle_pixel_decoder_unit.sv
